[rtl/pitch_to_scale_quantizer_macros.svh]
`ifndef PITCH_TO_SCALE_QUANTIZER_MACROS_SVH
`define PITCH_TO_SCALE_QUANTIZER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psq_pkg.sv]
package psq_pkg;

  localparam int FreqW        = 23;
  localparam int NoteW        = 9;
  localparam int CorrW        = 16;
  localparam int FreqFracBits = 8;
  localparam int Log2A4Q16    = 575495;
  localparam int NoteFullW    = 27;
  localparam int MantW        = 31;
  localparam int FracW        = 16;
  localparam int LeadW        = 5;
  localparam int SemiW        = 26;
  localparam int NumStages    = 24;
  // 69 + 12*(log2 f - frac bits - log2 440), constant part in Q16
  localparam int NoteOffs     = 69 * 65536 - 12 * (FreqFracBits * 65536 + Log2A4Q16);

  localparam logic [FreqW-1:0] FreqMax = {FreqW{1'b1}};

  typedef enum logic {
    RegRootNote  = 1'b0,
    RegScaleMask = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [4:0] quo;
    logic [3:0] rem;
  } dm12_t;

  // 440*2^(r/12) Hz in Q16
  function automatic logic [SemiW-1:0] semitone_hz(input logic [3:0] r);
    logic [SemiW-1:0] v;
    case (r)
      4'd0:    v = 26'd28835840;
      4'd1:    v = 26'd30550508;
      4'd2:    v = 26'd32367136;
      4'd3:    v = 26'd34291786;
      4'd4:    v = 26'd36330882;
      4'd5:    v = 26'd38491228;
      4'd6:    v = 26'd40780036;
      4'd7:    v = 26'd43204943;
      4'd8:    v = 26'd45774043;
      4'd9:    v = 26'd48495909;
      4'd10:   v = 26'd51379626;
      4'd11:   v = 26'd54434817;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

  // valid for v below 300: reciprocal multiply by 683/8192
  function automatic dm12_t divmod12(input logic [9:0] v);
    logic [19:0] prod;
    logic [9:0]  back;
    dm12_t       res;
    prod     = 20'(v) * 20'd683;
    res.quo  = prod[17:13];
    back     = 10'(res.quo) * 10'd12;
    res.rem  = 4'(v - back);
    return res;
  endfunction

  // fold a value below 24 into 0..11
  function automatic logic [3:0] wrap12(input logic [4:0] v);
    logic [4:0] w;
    w = (v >= 5'd12) ? v - 5'd12 : v;
    return w[3:0];
  endfunction

endpackage

[rtl/pitch_to_scale_quantizer.sv]
// Channel   Direction  Handshake                      Payload
// freq      in         freq_valid_i / freq_stall_o    freq_hz_i
// result    out        res_valid_o / res_stall_i      target_freq_o, target_note_o,
//                                                     correction_o, no_pitch_o
// config    in         APB psel/penable/pwrite        paddr, pwdata -> prdata
//
// 24-stage pipeline, one word per cycle unless the output stalls with every stage full;
// each word is registered in stages 0 to 23 in turn.
// The log2 takes 16 of those stages, one 31x31 squaring of the mantissa each.
// A stalled output holds; upstream stages keep moving until the bubbles close.
// Reset clears valid bits and sets root_note to 0 and scale_mask to all ones.
`include "pitch_to_scale_quantizer_macros.svh"

module pitch_to_scale_quantizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                freq_valid_i,
  output logic                                freq_stall_o,
  input  logic [psq_pkg::FreqW-1:0]           freq_hz_i,
  output logic                                res_valid_o,
  input  logic                                res_stall_i,
  output logic [psq_pkg::FreqW-1:0]           target_freq_o,
  output logic signed [psq_pkg::NoteW-1:0]    target_note_o,
  output logic signed [psq_pkg::CorrW-1:0]    correction_o,
  output logic                                no_pitch_o
);

  localparam int NS     = psq_pkg::NumStages;
  localparam int SLead  = 1;
  localparam int SSq0   = 2;
  localparam int SNote  = 18;
  localparam int SRound = 19;
  localparam int SClass = 20;
  localparam int SShift = 21;
  localparam int SDiff  = 22;
  localparam int SOut   = 23;
  localparam int NfW    = psq_pkg::NoteFullW;

  // ---------------- configuration ----------------
  logic [3:0]  root_q;
  logic [11:0] mask_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= 4'd0;
      mask_q <= 12'hFFF;
    end else if (cfg_wr) begin
      case (psq_pkg::reg_idx_e'(paddr[2]))
        psq_pkg::RegRootNote:  root_q <= pwdata[3:0];
        psq_pkg::RegScaleMask: mask_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (psq_pkg::reg_idx_e'(paddr[2]))
      psq_pkg::RegRootNote:  prdata = {28'd0, root_q};
      psq_pkg::RegScaleMask: prdata = {20'd0, mask_q};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;
  logic [NS-1:1] zero_q;

  // a stage advances unless it and every stage after it is full and the output stalls
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !res_stall_i || !(&valid_q[NS-1:k]);
  end

  assign freq_stall_o = !en[0];
  assign res_valid_o  = valid_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? freq_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  logic [psq_pkg::FreqW-1:0] f0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f0_q <= freq_hz_i;
    end
  end

  // zero-input flag: set at stage 1, then advance with the word
  always_ff @(posedge clk_i) begin
    if (en[SLead]) begin
      zero_q[SLead] <= (f0_q == '0);
    end
    for (int k = SLead + 1; k < NS; k++) begin
      if (en[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // ---------------- stage 1: leading one, normalize ----------------
  logic [psq_pkg::LeadW-1:0] lead_d;
  logic [psq_pkg::MantW-1:0] m_q  [0:16];
  logic [psq_pkg::FracW-1:0] fr_q [0:16];
  logic [psq_pkg::LeadW-1:0] p_q  [0:16];

  always_comb begin
    lead_d = '0;
    for (int i = 1; i < psq_pkg::FreqW; i++) begin
      if (f0_q[i]) begin
        lead_d = psq_pkg::LeadW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SLead]) begin
      m_q[0]         <= psq_pkg::MantW'(f0_q) << (5'd30 - lead_d);
      fr_q[0]        <= '0;
      p_q[0]         <= lead_d;
    end
  end

  // ---------------- stages 2..17: one squaring per fraction bit ----------------
  for (genvar k = 0; k < 16; k++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sq;

    assign prod = 62'(m_q[k]) * 62'(m_q[k]);
    assign sq   = prod[61:30];

    always_ff @(posedge clk_i) begin
      if (en[SSq0+k]) begin
        m_q[k+1]        <= sq[31] ? sq[31:1] : sq[30:0];
        fr_q[k+1]       <= fr_q[k] | (sq[31] ? (16'd1 << (15 - k)) : 16'd0);
        p_q[k+1]        <= p_q[k];
      end
    end
  end

  // ---------------- stage 18: fractional note, Q16 ----------------
  logic [20:0]           log2_d;
  logic signed [NfW-1:0] note_d;
  logic signed [NfW-1:0] note18_q, note19_q, note20_q, note21_q;

  assign log2_d = {p_q[16], fr_q[16]};
  assign note_d = $signed(NfW'({log2_d, 3'b000}) + NfW'({log2_d, 2'b00})
                          + NfW'(psq_pkg::NoteOffs));

  always_ff @(posedge clk_i) begin
    if (en[SNote]) begin
      note18_q      <= note_d;
    end
  end

  // ---------------- stage 19: round half away from zero ----------------
  logic [NfW-1:0]                  abs_note;
  logic [NfW-1:0]                  rnd_note;
  logic signed [psq_pkg::NoteW-1:0] n_d, n19_q, n20_q;

  assign abs_note = note18_q[NfW-1] ? NfW'(-note18_q) : NfW'(note18_q);
  assign rnd_note = abs_note + NfW'(32768);
  assign n_d      = note18_q[NfW-1] ? -$signed(rnd_note[24:16]) : $signed(rnd_note[24:16]);

  always_ff @(posedge clk_i) begin
    if (en[SRound]) begin
      n19_q          <= n_d;
      note19_q       <= note18_q;
    end
  end

  // ---------------- stage 20: pitch class ----------------
  psq_pkg::dm12_t pc_dm;
  logic [3:0]     pc20_q;

  // offset by 144 keeps the value positive without changing it mod 12
  assign pc_dm = psq_pkg::divmod12(10'($signed({n19_q[8], n19_q}) + 10'sd144));

  always_ff @(posedge clk_i) begin
    if (en[SClass]) begin
      pc20_q         <= pc_dm.rem;
      n20_q          <= n19_q;
      note20_q       <= note19_q;
    end
  end

  // ---------------- stage 21: nearest allowed class ----------------
  logic [3:0]                       root_m;
  logic [11:0]                      allowed;
  logic signed [3:0]                shift_d;
  logic                             found;
  logic signed [psq_pkg::NoteW-1:0] t21_q, t22_q;

  assign root_m = (root_q >= 4'd12) ? root_q - 4'd12 : root_q;

  always_comb begin
    for (int c = 0; c < 12; c++) begin
      allowed[c] = mask_q[psq_pkg::wrap12(5'(c) + 5'd12 - 5'(root_m))];
    end
  end

  // search down before up at each distance: a tie goes to the lower note
  always_comb begin
    shift_d = 4'sd0;
    found   = allowed[pc20_q];
    for (int d = 1; d <= 6; d++) begin
      if (!found) begin
        if (allowed[psq_pkg::wrap12(5'(pc20_q) + 5'(12 - d))]) begin
          shift_d = -4'(d);
          found   = 1'b1;
        end else if (allowed[psq_pkg::wrap12(5'(pc20_q) + 5'(d))]) begin
          shift_d = 4'(d);
          found   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SShift]) begin
      t21_q          <= n20_q + psq_pkg::NoteW'(shift_d);
      note21_q       <= note20_q;
    end
  end

  // ---------------- stage 22: correction difference, octave split ----------------
  logic signed [NfW-1:0] diff_q;
  psq_pkg::dm12_t        oct_dm;
  psq_pkg::dm12_t        oct22_q;

  // offset by 216 = 18 octaves keeps t - 69 positive
  assign oct_dm = psq_pkg::divmod12(10'($signed({t21_q[8], t21_q}) + 10'sd147));

  always_ff @(posedge clk_i) begin
    if (en[SDiff]) begin
      diff_q        <= $signed({{(NfW - psq_pkg::NoteW - 16){t21_q[psq_pkg::NoteW-1]}},
                                t21_q, 16'd0}) - note21_q;
      oct22_q       <= oct_dm;
      t22_q         <= t21_q;
    end
  end

  // ---------------- stage 23: output register ----------------
  logic signed [6:0]          shamt;
  logic [6:0]                 rshamt;
  logic [psq_pkg::SemiW-1:0]  semi;
  logic [34:0]                lsh;
  logic [47:0]                rsum;
  logic [47:0]                rsh;
  logic [psq_pkg::FreqW-1:0]  freq_d;
  logic [NfW-1:0]             abs_diff;
  logic [NfW-1:0]             rdiff;
  logic [22:0]                cmag;
  logic [psq_pkg::CorrW-1:0]  corr_d;

  assign shamt  = $signed(7'(oct22_q.quo) + 7'(psq_pkg::FreqFracBits) - 7'd34);
  assign rshamt = 7'(-shamt);
  assign semi   = psq_pkg::semitone_hz(oct22_q.rem);
  assign lsh    = 35'(semi) << shamt[3:0];
  assign rsum   = 48'(semi) + (48'd1 << (rshamt - 7'd1));
  assign rsh    = rsum >> rshamt;

  always_comb begin
    if (!shamt[6]) begin
      if (shamt > 7'sd8) begin
        freq_d = psq_pkg::FreqMax;
      end else begin
        freq_d = (lsh > 35'(psq_pkg::FreqMax)) ? psq_pkg::FreqMax : lsh[22:0];
      end
    end else if (rshamt > 7'd40) begin
      freq_d = '0;
    end else begin
      freq_d = (rsh > 48'(psq_pkg::FreqMax)) ? psq_pkg::FreqMax : rsh[22:0];
    end
  end

  assign abs_diff = diff_q[NfW-1] ? NfW'(-diff_q) : NfW'(diff_q);
  assign rdiff    = abs_diff + NfW'(8);
  assign cmag     = 23'(rdiff >> 4);

  // saturate to the 16-bit signed range
  always_comb begin
    if (!diff_q[NfW-1]) begin
      corr_d = (cmag > 23'd32767) ? 16'h7FFF : cmag[15:0];
    end else begin
      corr_d = (cmag > 23'd32768) ? 16'h8000 : 16'(-cmag[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SOut]) begin
      if (zero_q[SDiff]) begin
        target_freq_o <= '0;
        target_note_o <= '0;
        correction_o  <= '0;
      end else begin
        target_freq_o <= freq_d;
        target_note_o <= t22_q;
        correction_o  <= $signed(corr_d);
      end
    end
  end

  assign no_pitch_o = zero_q[SOut];

  // ---------------- assertions ----------------
  `PSQ_ASSERT_IMP(a_stall_only_full, freq_stall_o, &valid_q, "input stalled with a free stage")
  `PSQ_ASSERT_IMP(a_no_pitch_zero, res_valid_o && no_pitch_o,
    target_freq_o == '0 && target_note_o == '0 && correction_o == '0,
    "no_pitch word carries nonzero fields")
  `PSQ_ASSERT_NXT(a_drain_bubble, res_valid_o && !res_stall_i && !valid_q[NS-2],
    !res_valid_o, "output word repeated after take")

endmodule

[tb/sv/psq_checker.sv]
module psq_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  input  logic                             freq_valid_i,
  input  logic                             freq_stall_o,
  input  logic [psq_pkg::FreqW-1:0]        freq_hz_i,
  input  logic                             res_valid_o,
  input  logic                             res_stall_i,
  input  logic [psq_pkg::FreqW-1:0]        target_freq_o,
  input  logic signed [psq_pkg::NoteW-1:0] target_note_o,
  input  logic signed [psq_pkg::CorrW-1:0] correction_o,
  input  logic                             no_pitch_o,
  output int                               fail_cnt_o,
  output int                               pending_o
);
  import psq_pkg::*;

  typedef struct {
    logic [FreqW-1:0]        freq;
    logic signed [NoteW-1:0] note;
    logic signed [CorrW-1:0] corr;
    logic                    nop;
  } note_res_t;

  localparam longint SemiQ16 [12] = '{
    28835840, 30550508, 32367136, 34291786, 36330882, 38491228,
    40780036, 43204943, 45774043, 48495909, 51379626, 54434817
  };

  note_res_t  want_q[$];
  logic [3:0]  root_q;
  logic [11:0] mask_q;

  function automatic bit in_scale(int pc, logic [3:0] root, logic [11:0] mask);
    int rel;
    rel = ((pc - int'(root) % 12) % 12 + 12) % 12;
    return mask[rel];
  endfunction

  function automatic note_res_t quantize(logic [FreqW-1:0] f, logic [3:0] root,
                                         logic [11:0] mask);
    note_res_t   r;
    int          p, pc, sh, rr;
    longint      lg, fnote, n, t, diff, corr, e, q, s;
    longint unsigned m, v;
    r = '{default: '0};
    if (f == 0) begin
      r.nop = 1'b1;
      return r;
    end
    p = 0;
    while (p < 22 && (f >> (p + 1)) != 0) p++;
    m  = longint'(f) << (30 - p);
    lg = longint'(p) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        lg |= longint'(1) << i;
        m = m >> 1;
      end
    end
    fnote = 69 * 65536 + 12 * (lg - 8 * 65536 - 575495);
    if (fnote >= 0) n = (fnote + 32768) >>> 16;
    else n = -((-fnote + 32768) >>> 16);
    pc = int'(((n % 12) + 12) % 12);
    sh = 0;
    if (!in_scale(pc, root, mask)) begin
      // lower neighbor first, so ties go down
      for (int d = 1; d <= 6; d++) begin
        if (in_scale((pc + 12 - d) % 12, root, mask)) begin
          sh = -d;
          break;
        end
        if (in_scale((pc + d) % 12, root, mask)) begin
          sh = d;
          break;
        end
      end
    end
    t    = n + sh;
    diff = t * 65536 - fnote;
    if (diff >= 0) corr = (diff + 8) >>> 4;
    else corr = -((-diff + 8) >>> 4);
    if (corr > 32767) corr = 32767;
    if (corr < -32768) corr = -32768;
    e = t - 69;
    q = (e >= 0) ? e / 12 : -((-e + 11) / 12);
    rr = int'(e - 12 * q);
    v  = SemiQ16[rr];
    s  = q + 8 - 16;
    if (s >= 0) begin
      if (s > 8) v = FreqMax;
      else begin
        v = v << s;
        if (v > FreqMax) v = FreqMax;
      end
    end else if (-s > 40) v = 0;
    else begin
      v = (v + (64'd1 << (-s - 1))) >> (-s);
      if (v > FreqMax) v = FreqMax;
    end
    r.freq = v[FreqW-1:0];
    r.note = t[NoteW-1:0];
    r.corr = corr[CorrW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    note_res_t w;
    if (!rst_ni) begin
      root_q <= 4'd0;
      mask_q <= 12'hFFF;
      fail_cnt_o <= 0;
      want_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegScaleMask) mask_q <= pwdata[11:0];
        else root_q <= pwdata[3:0];
      end
      if (freq_valid_i && !freq_stall_o)
        want_q.push_back(quantize(freq_hz_i, root_q, mask_q));
      if (res_valid_o && !res_stall_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected word freq=%0d note=%0d", $time, target_freq_o,
                   target_note_o);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          w = want_q.pop_front();
          if (w.freq !== target_freq_o || w.note !== target_note_o ||
              w.corr !== correction_o || w.nop !== no_pitch_o) begin
            $display("%0t: expected freq=%0d note=%0d corr=%0d nop=%0b, got %0d %0d %0d %0b",
                     $time, w.freq, w.note, w.corr, w.nop, target_freq_o, target_note_o,
                     correction_o, no_pitch_o);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = want_q.size();
endmodule

[tb/sv/tb.sv]
module tb;
  import psq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic freq_valid_i = 1'b0;
  logic freq_stall_o;
  logic [FreqW-1:0] freq_hz_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  logic [FreqW-1:0] target_freq_o;
  logic signed [NoteW-1:0] target_note_o;
  logic signed [CorrW-1:0] correction_o;
  logic no_pitch_o;
  int fail_cnt, pending, cycles = 0, stall_left = 0;

  always #2 clk_i = ~clk_i;

  pitch_to_scale_quantizer uut (.*);

  psq_checker chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 500000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver backpressure: mostly short runs, now and then a long stall
  always @(negedge clk_i) begin
    int k;
    if (stall_left > 0) stall_left--;
    else begin
      k = $urandom_range(99);
      if (k < 60) begin
        res_stall_i = 1'b0;
        stall_left = $urandom_range(k < 10 ? 60 : 8, 1);
      end else begin
        res_stall_i = 1'b1;
        stall_left = (k < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // drop valid first so the last word is not taken again
  task automatic drain();
    freq_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send_word(logic [FreqW-1:0] f, bit gaps);
    int k, g;
    freq_valid_i = 1'b1;
    freq_hz_i = f;
    do @(posedge clk_i); while (freq_stall_o);
    @(negedge clk_i);
    k = $urandom_range(99);
    g = !gaps || k < 55 ? 0 : (k < 93 ? $urandom_range(3, 1) : $urandom_range(30, 5));
    if (g > 0) begin
      freq_valid_i = 1'b0;
      freq_hz_i = FreqW'($urandom);
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic random_burst(int cnt);
    logic [FreqW-1:0] f;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(3))
        0: f = FreqW'($urandom);
        1: f = FreqW'($urandom) >> $urandom_range(22);
        2: f = FreqW'(112640 + int'($urandom_range(4000)) - 2000);
        default: f = ($urandom_range(30) == 0) ? '0 : FreqW'($urandom_range(65535) + 256);
      endcase
      send_word(f, (i / 60) % 4 != 3);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    // corners at reset settings: silence, smallest, largest, A4, A4 +/- about a quarter tone
    send_word(23'd0, 1);   send_word(23'd1, 1);      send_word(23'h7FFFFF, 1);
    send_word(23'd112640, 1); send_word(23'd115975, 1); send_word(23'd109400, 1);
    send_word(23'd2, 1);   send_word(23'h400000, 1); send_word(23'd256, 1);
    random_burst(120);
    drain();
    // empty scale, root above eleven
    write_reg(RegRootNote, 32'd15);
    write_reg(RegScaleMask, 32'd0);
    send_word(23'd112640, 1); send_word(23'd1, 1); send_word(23'h7FFFFF, 1);
    random_burst(120);
    drain();
    // single class: six-semitone distance
    write_reg(RegRootNote, 32'd11);
    write_reg(RegScaleMask, 32'h001);
    random_burst(130);
    drain();
    // two classes a whole tone apart: ties between them
    write_reg(RegRootNote, 32'd12);
    write_reg(RegScaleMask, 32'h005);
    random_burst(130);
    drain();
    write_reg(RegRootNote, 32'd2);
    write_reg(RegScaleMask, 32'hAD5);
    random_burst(150);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(RegRootNote, 32'($urandom_range(15)));
      write_reg(RegScaleMask, 32'($urandom_range(4095)));
      random_burst(100);
      drain();
    end
    freq_valid_i = 1'b0;
    drain();
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/psq_pkg.sv
rtl/pitch_to_scale_quantizer.sv
tb/sv/psq_checker.sv
tb/sv/tb.sv
